FILE: hdl/gasp_pkg.sv
package gasp_pkg;
  localparam int GridW = 8;
  localparam int GridH = 8;
  localparam int Cells = GridW * GridH;
  localparam int CW = $clog2(GridW);
  localparam int CI = $clog2(Cells);
  localparam int NW = $clog2(Cells + 1);
  localparam logic [15:0] StepStr = 16'd256;
  localparam logic [15:0] StepDiag = 16'd362;
  localparam logic [15:0] CostMax = 16'hffff;
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncSearch = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_INIT, S_SCAN, S_SCANW, S_EXP, S_NRD, S_NWAIT, S_NUPD,
    S_TRD, S_TWAIT, S_ERD, S_EMIT, S_FAIL
  } state_t;

  function automatic logic [16*Cells-1:0] heur_gen();
    logic [16*Cells-1:0] tab;
    logic [31:0] n, s, t;
    tab = '0;
    for (int dx = 0; dx < GridW; dx++) begin
      for (int dy = 0; dy < GridH; dy++) begin
        n = 32'd65536 * 32'(dx * dx + dy * dy);
        s = 32'd0;
        for (int b = 15; b >= 0; b--) begin
          t = s | (32'd1 << b);
          if (t * t <= n) s = t;
        end
        if (n - s * s > s) s = s + 32'd1;
        tab[(dx * GridH + dy) * 16 +: 16] = s[15:0];
      end
    end
    return tab;
  endfunction

  localparam logic [16*Cells-1:0] HeurTab = heur_gen();

  function automatic logic [15:0] heur(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                       input logic [CW-1:0] bx, input logic [CW-1:0] by);
    logic [CW-1:0] dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return HeurTab[{dx, dy, 4'd0} +: 16];
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? CostMax : s[15:0];
  endfunction
endpackage

FILE: hdl/gasp_ram.sv
module gasp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/grid_astar_path_search.sv
// A* search over an 8x8 8-connected grid.
// Issue a word by raising start while busy is low. func 0 writes one wall bit
// (cell_x, cell_y, wall) and returns nothing; func 1 searches from start to goal.
// A search answers with one out_valid strobe per path cell, start first, the
// final strobe with out_last high. Without a path one strobe carries found=0.
// Path strobes cannot be held off by the receiver. Cost and parent data live in
// one RAM with a registered read port, the walls in a second RAM. Each expansion
// scans all 64 cells through the RAM read port, picks the open cell with the
// lowest f, then walks the 9 neighbor slots, reading cost and wall for each
// in-grid candidate that is not closed, and finishes. The parent chain is then
// reversed in place and the path is emitted from start to goal. A write leaves
// busy low, so a new word may follow at once.
// After reset the wall RAM is cleared one cell per cycle with busy high; open
// and closed flags are flip-flops cleared at each search start.
module grid_astar_path_search (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [2:0]           in_cell_x,
  input  logic [2:0]           in_cell_y,
  input  logic                 in_wall,
  input  logic [2:0]           in_start_x,
  input  logic [2:0]           in_start_y,
  input  logic [2:0]           in_goal_x,
  input  logic [2:0]           in_goal_y,
  output logic                 out_valid,
  output logic [2:0]           out_path_x,
  output logic [2:0]           out_path_y,
  output logic                 out_found,
  output logic                 out_last
);
  import gasp_pkg::*;

  state_t state_r, state_nxt;
  logic [Cells-1:0] open_r, open_nxt, closed_r, closed_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CI-1:0] start_r, start_nxt, goal_r, goal_nxt, best_r, best_nxt;
  logic [CI-1:0] cur_r, cur_nxt;
  logic [15:0] bestf_r, bestf_nxt, bestg_r, bestg_nxt;
  logic have_r, have_nxt;
  logic [3:0] nb_r, nb_nxt;
  logic [CI-1:0] nc_r, nc_nxt;
  logic [NW-1:0] plen_r, plen_nxt;

  logic cw_we;
  logic [CI-1:0] cw_waddr, c_raddr;
  logic [37:0] cw_wdata, c_rdata;
  logic w_we, w_rdata;
  logic [CI-1:0] w_waddr, w_raddr;
  logic w_wdata;

  gasp_ram #(.Width(38), .Depth(Cells)) u_cost (
    .clk, .we(cw_we), .waddr(cw_waddr), .wdata(cw_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );
  gasp_ram #(.Width(1), .Depth(Cells)) u_wall (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
  );

  logic [15:0] rd_g, rd_f;
  logic [CI-1:0] rd_p;
  assign rd_g = c_rdata[37:22];
  assign rd_f = c_rdata[21:6];
  assign rd_p = c_rdata[5:0];

  logic [CI-1:0] scan_c;
  logic [2:0] bx, by, gx, gy, nxv, nyv;
  logic signed [4:0] ddx, ddy, nxs, nys;
  logic nb_ok, diag;
  logic [15:0] tg;

  assign scan_c = {cnt_r[2:0], cnt_r[5:3]};
  assign bx = best_r[2:0];
  assign by = best_r[5:3];
  assign gx = goal_r[2:0];
  assign gy = goal_r[5:3];

  always_comb begin
    case (nb_r)
      4'd0: begin ddx = -5'sd1; ddy = -5'sd1; end
      4'd1: begin ddx = -5'sd1; ddy = 5'sd0; end
      4'd2: begin ddx = -5'sd1; ddy = 5'sd1; end
      4'd3: begin ddx = 5'sd0; ddy = -5'sd1; end
      4'd4: begin ddx = 5'sd0; ddy = 5'sd0; end
      4'd5: begin ddx = 5'sd0; ddy = 5'sd1; end
      4'd6: begin ddx = 5'sd1; ddy = -5'sd1; end
      4'd7: begin ddx = 5'sd1; ddy = 5'sd0; end
      4'd8: begin ddx = 5'sd1; ddy = 5'sd1; end
      default: begin ddx = 5'sd0; ddy = 5'sd0; end
    endcase
  end

  assign nxs = $signed({2'b00, bx}) + ddx;
  assign nys = $signed({2'b00, by}) + ddy;
  assign nxv = nxs[2:0];
  assign nyv = nys[2:0];
  assign nb_ok = (nxs >= 5'sd0) && (nxs < 5'sd8) && (nys >= 5'sd0) && (nys < 5'sd8) &&
                 (nb_r != 4'd4);
  assign diag = (ddx != 5'sd0) && (ddy != 5'sd0);
  assign tg = sat_add(bestg_r, diag ? StepDiag : StepStr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      open_r <= '0;
      closed_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      open_r <= open_nxt;
      closed_r <= closed_nxt;
      cnt_r <= cnt_nxt;
    end
    start_r <= start_nxt;
    goal_r <= goal_nxt;
    best_r <= best_nxt;
    cur_r <= cur_nxt;
    bestf_r <= bestf_nxt;
    bestg_r <= bestg_nxt;
    have_r <= have_nxt;
    nb_r <= nb_nxt;
    nc_r <= nc_nxt;
    plen_r <= plen_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    open_nxt = open_r;
    closed_nxt = closed_r;
    cnt_nxt = cnt_r;
    start_nxt = start_r;
    goal_nxt = goal_r;
    best_nxt = best_r;
    cur_nxt = cur_r;
    bestf_nxt = bestf_r;
    bestg_nxt = bestg_r;
    have_nxt = have_r;
    nb_nxt = nb_r;
    nc_nxt = nc_r;
    plen_nxt = plen_r;
    cw_we = 1'b0;
    cw_waddr = nc_r;
    cw_wdata = '0;
    c_raddr = scan_c;
    w_we = 1'b0;
    w_waddr = {in_cell_y, in_cell_x};
    w_wdata = in_wall;
    w_raddr = {nyv, nxv};
    busy = 1'b1;
    out_valid = 1'b0;
    out_path_x = '0;
    out_path_y = '0;
    out_found = 1'b0;
    out_last = 1'b0;
    case (state_r)
      S_CLR: begin
        w_we = 1'b1;
        w_waddr = cnt_r[CI-1:0];
        w_wdata = 1'b0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(Cells - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_func == FuncWrite) begin
            w_we = 1'b1;
          end else begin
            start_nxt = {in_start_y, in_start_x};
            goal_nxt = {in_goal_y, in_goal_x};
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        open_nxt = '0;
        closed_nxt = '0;
        open_nxt[start_r] = 1'b1;
        cw_we = 1'b1;
        cw_waddr = start_r;
        cw_wdata = {16'd0, heur(start_r[2:0], start_r[5:3], gx, gy), 6'd0};
        cnt_nxt = '0;
        have_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cur_nxt = scan_c;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_SCANW;
      end
      S_SCANW: begin
        if (open_r[cur_r] && (!have_r || rd_f < bestf_r)) begin
          have_nxt = 1'b1;
          best_nxt = cur_r;
          bestf_nxt = rd_f;
          bestg_nxt = rd_g;
        end
        cur_nxt = scan_c;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(Cells)) state_nxt = S_EXP;
      end
      S_EXP: begin
        if (!have_r) state_nxt = S_FAIL;
        else if (best_r == goal_r) begin
          cur_nxt = goal_r;
          nc_nxt = goal_r;
          plen_nxt = '0;
          state_nxt = S_TRD;
        end else begin
          open_nxt[best_r] = 1'b0;
          closed_nxt[best_r] = 1'b1;
          nb_nxt = '0;
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        if (nb_r == 4'd9) begin
          cnt_nxt = '0;
          have_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else if (!nb_ok || closed_r[{nyv, nxv}]) begin
          nb_nxt = nb_r + 1'b1;
        end else begin
          c_raddr = {nyv, nxv};
          nc_nxt = {nyv, nxv};
          state_nxt = S_NWAIT;
        end
      end
      S_NWAIT: begin
        c_raddr = nc_r;
        state_nxt = S_NUPD;
      end
      S_NUPD: begin
        if (!w_rdata && (!open_r[nc_r] || tg < rd_g)) begin
          open_nxt[nc_r] = 1'b1;
          cw_we = 1'b1;
          cw_waddr = nc_r;
          cw_wdata = {tg, sat_add(tg, heur(nxv, nyv, gx, gy)), best_r};
        end
        nb_nxt = nb_r + 1'b1;
        state_nxt = S_NRD;
      end
      S_TRD: begin
        plen_nxt = plen_r + 1'b1;
        if (cur_r == start_r) begin
          cw_we = 1'b1;
          cw_waddr = cur_r;
          cw_wdata = {32'd0, nc_r};
          state_nxt = S_ERD;
        end else if (plen_r == NW'(Cells - 1)) begin
          state_nxt = S_FAIL;
        end else begin
          c_raddr = cur_r;
          state_nxt = S_TWAIT;
        end
      end
      S_TWAIT: begin
        cw_we = 1'b1;
        cw_waddr = cur_r;
        cw_wdata = {32'd0, nc_r};
        nc_nxt = cur_r;
        cur_nxt = rd_p;
        state_nxt = S_TRD;
      end
      S_ERD: begin
        c_raddr = cur_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        out_path_x = cur_r[2:0];
        out_path_y = cur_r[5:3];
        out_found = 1'b1;
        out_last = (cur_r == goal_r);
        cur_nxt = rd_p;
        if (cur_r == goal_r) state_nxt = S_IDLE;
        else state_nxt = S_ERD;
      end
      S_FAIL: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_no_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid) else $error("strobe while idle");
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last) else $error("fail not last");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid) else $error("strobe after last");
  a_closed_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NRD) |-> !open_r[best_r]) else $error("expanded cell still open");
endmodule
